@@ rtl/tfs_pkg.sv @@
`timescale 1ns / 1ps

package tfs_pkg;

	localparam int COUNT_WIDTH_DEF = 8;

	localparam logic [7:0] REVERSE_DELAY_RST = 8'd30;
	localparam logic [6:0] DRIVE_SPEED_RST   = 7'd100;
	localparam logic [6:0] SPEED_MAX         = 7'd100;

	typedef enum logic [0:0] {
		CFG_REVERSE_DELAY = 1'b0,
		CFG_DRIVE_SPEED   = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		OP_TICK = 1'b0,
		OP_ADD  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		PH_INIT     = 3'd0,
		PH_IDLE     = 3'd1,
		PH_FWD      = 3'd2,
		PH_REVPEEL  = 3'd3,
		PH_REVSPROC = 3'd4,
		PH_RUN      = 3'd5,
		PH_STOP     = 3'd6,
		PH_ERROR    = 3'd7
	} ph_t;

	typedef enum logic [2:0] {
		PL_OFF     = 3'd0,
		PL_FWD     = 3'd1,
		PL_REV     = 3'd2,
		PL_FWDDONE = 3'd3,
		PL_REVDONE = 3'd4
	} pl_t;

	typedef struct packed {
		logic [7:0] reverse_delay;
		logic [6:0] drive_speed;
	} cfg_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] request_count;
		logic       tape_switch;
		logic       reverse_button;
		logic       encoder_trigger;
	} item_t;

	// machine state apart from the pending count
	typedef struct packed {
		ph_t        feeder;
		pl_t        peel;
		logic [7:0] wait_timer;
		logic [6:0] sprocket_speed;
		logic       sprocket_reverse;
		logic [6:0] tape_speed;
		logic       tape_reverse;
		logic       error_led;
	} fsm_t;

	typedef struct packed {
		logic [6:0] sprocket_speed;
		logic       sprocket_reverse;
		logic [6:0] tape_speed;
		logic       tape_reverse;
		logic       encoder_clear;
		logic       trigger_ack;
		logic       error_led;
		ph_t        feeder_phase;
		pl_t        peel_phase;
		logic [7:0] pending_steps;
	} result_t;

endpackage

@@ rtl/tfs_cfg.sv @@
`timescale 1ns / 1ps

module tfs_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [0:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output tfs_pkg::cfg_t     cfg
);

	tfs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_delay <= tfs_pkg::REVERSE_DELAY_RST;
			cfg_q.drive_speed   <= tfs_pkg::DRIVE_SPEED_RST;
		end else if (cfg_valid) begin
			unique case (tfs_pkg::cfg_idx_t'(cfg_index))
				tfs_pkg::CFG_REVERSE_DELAY: cfg_q.reverse_delay <= cfg_data;
				tfs_pkg::CFG_DRIVE_SPEED:   cfg_q.drive_speed   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/tfs_step.sv @@
`timescale 1ns / 1ps

module tfs_step #(
	parameter int COUNT_WIDTH = tfs_pkg::COUNT_WIDTH_DEF
) (
	input  tfs_pkg::item_t                 item,
	input  tfs_pkg::cfg_t                  cfg,
	input  tfs_pkg::fsm_t                  st,
	input  logic signed [COUNT_WIDTH-1:0]  pending,
	output tfs_pkg::fsm_t                  st_nxt,
	output logic signed [COUNT_WIDTH-1:0]  pending_nxt,
	output tfs_pkg::result_t               res
);

	localparam int DW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam int SW = DW + 1;
	localparam logic signed [SW-1:0] PEND_MAX = SW'((64'sd1 <<< (COUNT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] PEND_MIN = SW'(-(64'sd1 <<< (COUNT_WIDTH - 1)));
	localparam logic signed [DW-1:0] SHOW_MAX = DW'(64'sd127);
	localparam logic signed [DW-1:0] SHOW_MIN = DW'(-64'sd128);

	logic [6:0]                    on_spd;
	logic signed [SW-1:0]          sum;
	logic signed [COUNT_WIDTH-1:0] sat;
	logic signed [DW-1:0]          shown_w;
	logic [7:0]                    shown;
	logic                          wait_more;

	tfs_pkg::ph_t                  ph_f;
	tfs_pkg::pl_t                  pl_f;
	tfs_pkg::pl_t                  pl_p;
	logic signed [COUNT_WIDTH-1:0] pend_f;
	logic [7:0]                    wait_f;
	logic [6:0]                    spr_spd_f;
	logic                          spr_rev_f;
	logic [6:0]                    tape_spd_f;
	logic                          tape_rev_f;
	logic [6:0]                    tape_spd_p;
	logic                          tape_rev_p;
	logic                          clr_f;
	logic                          ack_f;
	logic                          led_f;
	logic                          clr_o;
	logic                          ack_o;

	assign on_spd    = (cfg.drive_speed > tfs_pkg::SPEED_MAX) ? tfs_pkg::SPEED_MAX
	                                                          : cfg.drive_speed;
	assign wait_more = st.wait_timer < cfg.reverse_delay;

	// saturating add of a feed request
	always_comb begin
		sum = SW'(pending) + SW'($signed(item.request_count));
		if (sum > PEND_MAX)
			sat = COUNT_WIDTH'(PEND_MAX);
		else if (sum < PEND_MIN)
			sat = COUNT_WIDTH'(PEND_MIN);
		else
			sat = COUNT_WIDTH'(sum);
	end

	// feeder next state
	always_comb begin
		ph_f   = st.feeder;
		pl_f   = st.peel;
		pend_f = pending;
		wait_f = st.wait_timer;
		unique case (st.feeder)
			tfs_pkg::PH_INIT: begin
				pl_f = tfs_pkg::PL_OFF;
				ph_f = tfs_pkg::PH_IDLE;
			end
			tfs_pkg::PH_IDLE: begin
				priority if (!pending[COUNT_WIDTH-1] && (pending != '0)) begin
					ph_f   = tfs_pkg::PH_FWD;
					pend_f = pending - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
				end else if (pending[COUNT_WIDTH-1]) begin
					ph_f   = tfs_pkg::PH_REVPEEL;
					pend_f = pending + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
				end else if (item.reverse_button) begin
					ph_f = tfs_pkg::PH_STOP;
					pl_f = tfs_pkg::PL_OFF;
				end else begin
				end
			end
			tfs_pkg::PH_FWD: begin
				ph_f = tfs_pkg::PH_RUN;
				pl_f = tfs_pkg::PL_FWD;
			end
			tfs_pkg::PH_REVPEEL: begin
				pl_f   = tfs_pkg::PL_REV;
				wait_f = '0;
				ph_f   = tfs_pkg::PH_REVSPROC;
			end
			tfs_pkg::PH_REVSPROC: begin
				if (wait_more) begin
					wait_f = st.wait_timer + 8'd1;
				end else begin
					ph_f = tfs_pkg::PH_RUN;
					pl_f = tfs_pkg::PL_REVDONE;
				end
			end
			tfs_pkg::PH_RUN: begin
				// button wins over trigger
				if (item.reverse_button) begin
					ph_f = tfs_pkg::PH_STOP;
					pl_f = tfs_pkg::PL_OFF;
				end else if (item.encoder_trigger) begin
					ph_f = tfs_pkg::PH_IDLE;
					pl_f = tfs_pkg::PL_FWDDONE;
				end
			end
			tfs_pkg::PH_STOP: ph_f = tfs_pkg::PH_IDLE;
			default:          ph_f = tfs_pkg::PH_ERROR;
		endcase
	end

	// feeder outputs
	always_comb begin
		spr_spd_f  = st.sprocket_speed;
		spr_rev_f  = st.sprocket_reverse;
		tape_spd_f = st.tape_speed;
		tape_rev_f = st.tape_reverse;
		clr_f      = 1'b0;
		ack_f      = 1'b0;
		led_f      = st.error_led;
		unique case (st.feeder)
			tfs_pkg::PH_INIT: begin
				clr_f      = 1'b1;
				spr_spd_f  = '0;
				spr_rev_f  = 1'b0;
				tape_spd_f = '0;
				tape_rev_f = 1'b0;
			end
			tfs_pkg::PH_IDLE: clr_f = 1'b1;
			tfs_pkg::PH_FWD: begin
				spr_spd_f = on_spd;
				spr_rev_f = 1'b0;
			end
			tfs_pkg::PH_REVPEEL: ;
			tfs_pkg::PH_REVSPROC: begin
				if (!wait_more) begin
					spr_spd_f = on_spd;
					spr_rev_f = 1'b1;
				end
			end
			tfs_pkg::PH_RUN:  ack_f = item.encoder_trigger;
			tfs_pkg::PH_STOP: begin
				spr_spd_f = '0;
				spr_rev_f = 1'b0;
			end
			default: led_f = ~st.error_led;
		endcase
	end

	// peeler runs on the phase the feeder left
	always_comb begin
		pl_p       = pl_f;
		tape_spd_p = tape_spd_f;
		tape_rev_p = tape_rev_f;
		unique case (pl_f)
			tfs_pkg::PL_OFF: begin
				tape_spd_p = '0;
				tape_rev_p = 1'b0;
			end
			tfs_pkg::PL_FWD: begin
				if (!item.tape_switch) begin
					tape_spd_p = on_spd;
					tape_rev_p = 1'b0;
				end
			end
			tfs_pkg::PL_REV: begin
				tape_spd_p = on_spd;
				tape_rev_p = 1'b1;
			end
			tfs_pkg::PL_FWDDONE: if (item.tape_switch)  pl_p = tfs_pkg::PL_OFF;
			tfs_pkg::PL_REVDONE: if (!item.tape_switch) pl_p = tfs_pkg::PL_OFF;
			default: pl_p = tfs_pkg::PL_OFF;
		endcase
	end

	always_comb begin
		st_nxt      = st;
		pending_nxt = pending;
		clr_o       = 1'b0;
		ack_o       = 1'b0;
		unique case (item.operation)
			tfs_pkg::OP_ADD: pending_nxt = sat;
			tfs_pkg::OP_TICK: begin
				st_nxt.feeder           = ph_f;
				st_nxt.peel             = pl_p;
				st_nxt.wait_timer       = wait_f;
				st_nxt.sprocket_speed   = spr_spd_f;
				st_nxt.sprocket_reverse = spr_rev_f;
				st_nxt.tape_speed       = tape_spd_p;
				st_nxt.tape_reverse     = tape_rev_p;
				st_nxt.error_led        = led_f;
				pending_nxt             = pend_f;
				clr_o                   = clr_f;
				ack_o                   = ack_f;
			end
			default: ;
		endcase
	end

	// shown count clamps to the 8-bit result field
	always_comb begin
		shown_w = DW'(pending_nxt);
		if (shown_w > SHOW_MAX)
			shown = SHOW_MAX[7:0];
		else if (shown_w < SHOW_MIN)
			shown = SHOW_MIN[7:0];
		else
			shown = shown_w[7:0];
		res.sprocket_speed   = st_nxt.sprocket_speed;
		res.sprocket_reverse = st_nxt.sprocket_reverse;
		res.tape_speed       = st_nxt.tape_speed;
		res.tape_reverse     = st_nxt.tape_reverse;
		res.encoder_clear    = clr_o;
		res.trigger_ack      = ack_o;
		res.error_led        = st_nxt.error_led;
		res.feeder_phase     = st_nxt.feeder;
		res.peel_phase       = st_nxt.peel;
		res.pending_steps    = shown;
	end

endmodule

@@ rtl/tape_feeder_sequencer.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// cfg       in         cfg_valid/cfg_ready   cfg_index[0:0], cfg_data[7:0]
// in        in         in_valid/in_ready     operation, request_count, tape_switch,
//                                            reverse_button, encoder_trigger
// out       out        out_valid/out_ready   sprocket_*, tape_*, encoder_clear,
//                                            trigger_ack, error_led, *_phase, pending_steps
//
// one beat per clock on in and out while out_ready is high; each input beat goes
// through the input register, then one pass of step logic into the result register
// the machine state updates in the same edge that loads the result register
// arst_n puts the feeder in init, peeler off, drives stopped, pending count zero,
// delay 30 ticks, speed 100
// a stalled out channel holds the result and the input register; in_ready drops
// only when both are full
// cfg_ready is always high

module tape_feeder_sequencer #(
	parameter int COUNT_WIDTH = tfs_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic signed [7:0] request_count,
	input  logic        tape_switch,
	input  logic        reverse_button,
	input  logic        encoder_trigger,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  sprocket_speed,
	output logic        sprocket_reverse,
	output logic [6:0]  tape_speed,
	output logic        tape_reverse,
	output logic        encoder_clear,
	output logic        trigger_ack,
	output logic        error_led,
	output logic [2:0]  feeder_phase,
	output logic [2:0]  peel_phase,
	output logic signed [7:0] pending_steps
);

	tfs_pkg::cfg_t    cfg;

	// input register
	logic             valid_s1;
	tfs_pkg::item_t   item_s1;

	// machine state
	tfs_pkg::fsm_t                 st_q;
	logic signed [COUNT_WIDTH-1:0] pending_q;

	tfs_pkg::fsm_t                 st_nxt;
	logic signed [COUNT_WIDTH-1:0] pending_nxt;
	tfs_pkg::result_t              res;

	// result register
	logic             valid_s2;
	tfs_pkg::result_t res_s2;

	logic             adv;

	tfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register free or draining this cycle
	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.operation       <= tfs_pkg::op_t'(operation);
			item_s1.request_count   <= request_count;
			item_s1.tape_switch     <= tape_switch;
			item_s1.reverse_button  <= reverse_button;
			item_s1.encoder_trigger <= encoder_trigger;
		end
	end

	tfs_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.item        (item_s1),
		.cfg         (cfg),
		.st          (st_q),
		.pending     (pending_q),
		.st_nxt      (st_nxt),
		.pending_nxt (pending_nxt),
		.res         (res)
	);

	// state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.feeder           <= tfs_pkg::PH_INIT;
			st_q.peel             <= tfs_pkg::PL_OFF;
			st_q.wait_timer       <= '0;
			st_q.sprocket_speed   <= '0;
			st_q.sprocket_reverse <= 1'b0;
			st_q.tape_speed       <= '0;
			st_q.tape_reverse     <= 1'b0;
			st_q.error_led        <= 1'b0;
			pending_q             <= '0;
		end else if (valid_s1 && adv) begin
			st_q      <= st_nxt;
			pending_q <= pending_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign sprocket_speed   = res_s2.sprocket_speed;
	assign sprocket_reverse = res_s2.sprocket_reverse;
	assign tape_speed       = res_s2.tape_speed;
	assign tape_reverse     = res_s2.tape_reverse;
	assign encoder_clear    = res_s2.encoder_clear;
	assign trigger_ack      = res_s2.trigger_ack;
	assign error_led        = res_s2.error_led;
	assign feeder_phase     = res_s2.feeder_phase;
	assign peel_phase       = res_s2.peel_phase;
	assign pending_steps    = res_s2.pending_steps;

endmodule

@@ rtl/tfs_checker.sv @@
`timescale 1ns / 1ps

module tfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] sprocket_speed,
	input logic       encoder_clear,
	input logic       trigger_ack,
	input logic [2:0] feeder_phase,
	input logic [7:0] pending_steps
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(feeder_phase)
			&& $stable(pending_steps) && $stable(sprocket_speed))
		else $error("result changed while stalled");

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sprocket_speed <= tfs_pkg::SPEED_MAX)
		else $error("sprocket speed above cap");

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(encoder_clear && trigger_ack))
		else $error("encoder clear and trigger ack in one tick");

	// ack only leaves the run phase toward idle or stop
	a_ack_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_ack |->
			(feeder_phase == tfs_pkg::PH_IDLE) || (feeder_phase == tfs_pkg::PH_STOP))
		else $error("trigger ack with wrong phase");

	// clear only comes out of init or idle
	a_clr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && encoder_clear |->
			(feeder_phase == tfs_pkg::PH_IDLE) || (feeder_phase == tfs_pkg::PH_FWD)
			|| (feeder_phase == tfs_pkg::PH_REVPEEL) || (feeder_phase == tfs_pkg::PH_STOP))
		else $error("encoder clear with wrong phase");

endmodule

bind tape_feeder_sequencer tfs_checker u_tfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.sprocket_speed (sprocket_speed),
	.encoder_clear  (encoder_clear),
	.trigger_ack    (trigger_ack),
	.feeder_phase   (feeder_phase),
	.pending_steps  (pending_steps)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import tfs_pkg::*;

	// dut ports, all inputs known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [0:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              operation = 1'b0;
	logic signed [7:0] request_count = '0;
	logic              tape_switch = 1'b0;
	logic              reverse_button = 1'b0;
	logic              encoder_trigger = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [6:0]        sprocket_speed;
	logic              sprocket_reverse;
	logic [6:0]        tape_speed;
	logic              tape_reverse;
	logic              encoder_clear;
	logic              trigger_ack;
	logic              error_led;
	logic [2:0]        feeder_phase;
	logic [2:0]        peel_phase;
	logic signed [7:0] pending_steps;

	tape_feeder_sequencer dut (.*);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// shadow copy of the feeder: registers and both machines
	logic [7:0]        delay_cfg = REVERSE_DELAY_RST;
	logic [6:0]        speed_cfg = DRIVE_SPEED_RST;
	ph_t               fd_ph = PH_INIT;
	pl_t               pl_ph = PL_OFF;
	logic signed [7:0] pend_cnt = '0;
	logic [7:0]        wait_cnt = '0;
	logic [6:0]        spr_spd = '0;
	logic              spr_rev = 1'b0;
	logic [6:0]        tp_spd = '0;
	logic              tp_rev = 1'b0;
	logic              led = 1'b0;

	// commands waiting for the driver, and the status beats they will cause
	item_t   feed_cmds[$];
	result_t status_due[$];
	item_t   cur_cmd;

	int n_queued = 0;
	int n_accepted = 0;
	int results_seen = 0;
	int errors = 0;
	int ticks_sent = 0;
	int adds_sent = 0;
	int stall_cycles = 0;
	int acks_seen = 0;
	int rev_starts = 0;
	int clamped = 0;

	// idle shaping: calm turns all gaps off, hold_off is the long receiver stall
	logic calm = 1'b0;
	logic hold_off = 1'b0;
	int   tx_gap = 0;
	int   rx_gap = 0;
	logic sw_level = 1'b0;

	function automatic logic [6:0] on_speed();
		return (speed_cfg > SPEED_MAX) ? SPEED_MAX : speed_cfg;
	endfunction

	// one item through the feeder: request add or tick, then the status it shows
	task automatic advance_feeder(input item_t cmd, output result_t res);
		logic clr;
		logic ack;
		int   sum;
		clr = 1'b0;
		ack = 1'b0;
		if (cmd.operation == OP_ADD) begin
			// saturating add into the signed pending count
			sum = int'(pend_cnt) + int'($signed(cmd.request_count));
			if (sum > 127 || sum < -128) clamped++;
			if (sum > 127) sum = 127;
			if (sum < -128) sum = -128;
			pend_cnt = sum[7:0];
		end else begin
			// feeder machine first
			case (fd_ph)
				PH_INIT: begin
					clr = 1'b1;
					pl_ph = PL_OFF;
					spr_spd = '0;
					spr_rev = 1'b0;
					tp_spd = '0;
					tp_rev = 1'b0;
					fd_ph = PH_IDLE;
				end
				PH_IDLE: begin
					clr = 1'b1;
					if (pend_cnt > 0) begin
						fd_ph = PH_FWD;
						pend_cnt = pend_cnt - 8'sd1;
					end else if (pend_cnt < 0) begin
						fd_ph = PH_REVPEEL;
						pend_cnt = pend_cnt + 8'sd1;
					end else if (cmd.reverse_button) begin
						fd_ph = PH_STOP;
						pl_ph = PL_OFF;
					end
				end
				PH_FWD: begin
					spr_spd = on_speed();
					spr_rev = 1'b0;
					fd_ph = PH_RUN;
					pl_ph = PL_FWD;
				end
				PH_REVPEEL: begin
					pl_ph = PL_REV;
					wait_cnt = '0;
					fd_ph = PH_REVSPROC;
				end
				PH_REVSPROC: begin
					// button and trigger do not matter while waiting
					if (wait_cnt < delay_cfg) begin
						wait_cnt = wait_cnt + 8'd1;
					end else begin
						spr_spd = on_speed();
						spr_rev = 1'b1;
						fd_ph = PH_RUN;
						pl_ph = PL_REVDONE;
						rev_starts++;
					end
				end
				PH_RUN: begin
					// sprocket keeps running after the trigger; button wins over it
					if (cmd.encoder_trigger) begin
						ack = 1'b1;
						fd_ph = PH_IDLE;
						pl_ph = PL_FWDDONE;
					end
					if (cmd.reverse_button) begin
						fd_ph = PH_STOP;
						pl_ph = PL_OFF;
					end
				end
				PH_STOP: begin
					spr_spd = '0;
					spr_rev = 1'b0;
					fd_ph = PH_IDLE;
				end
				default: begin
					led = ~led;
					fd_ph = PH_ERROR;
				end
			endcase
			// then the peeler
			case (pl_ph)
				PL_OFF: begin
					tp_spd = '0;
					tp_rev = 1'b0;
				end
				PL_FWD: begin
					if (!cmd.tape_switch) begin
						tp_spd = on_speed();
						tp_rev = 1'b0;
					end
				end
				PL_REV: begin
					tp_spd = on_speed();
					tp_rev = 1'b1;
				end
				PL_FWDDONE: begin
					if (cmd.tape_switch) pl_ph = PL_OFF;
				end
				PL_REVDONE: begin
					if (!cmd.tape_switch) pl_ph = PL_OFF;
				end
				default: begin
					pl_ph = PL_OFF;
				end
			endcase
		end
		if (ack) acks_seen++;
		res.sprocket_speed = spr_spd;
		res.sprocket_reverse = spr_rev;
		res.tape_speed = tp_spd;
		res.tape_reverse = tp_rev;
		res.encoder_clear = clr;
		res.trigger_ack = ack;
		res.error_led = led;
		res.feeder_phase = fd_ph;
		res.peel_phase = pl_ph;
		res.pending_steps = pend_cnt;
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 96) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// output capped so a broken dut cannot flood the log
	task automatic report(input string msg);
		errors++;
		if (errors <= 40) $display("ERROR at result %0d: %s", results_seen, msg);
	endtask

	task automatic check_status(input result_t want);
		if (sprocket_speed !== want.sprocket_speed)
			report($sformatf("sprocket_speed got %0h want %0h", sprocket_speed,
				want.sprocket_speed));
		if (sprocket_reverse !== want.sprocket_reverse)
			report($sformatf("sprocket_reverse got %0h want %0h", sprocket_reverse,
				want.sprocket_reverse));
		if (tape_speed !== want.tape_speed)
			report($sformatf("tape_speed got %0h want %0h", tape_speed, want.tape_speed));
		if (tape_reverse !== want.tape_reverse)
			report($sformatf("tape_reverse got %0h want %0h", tape_reverse,
				want.tape_reverse));
		if (encoder_clear !== want.encoder_clear)
			report($sformatf("encoder_clear got %0h want %0h", encoder_clear,
				want.encoder_clear));
		if (trigger_ack !== want.trigger_ack)
			report($sformatf("trigger_ack got %0h want %0h", trigger_ack, want.trigger_ack));
		if (error_led !== want.error_led)
			report($sformatf("error_led got %0h want %0h", error_led, want.error_led));
		if (feeder_phase !== want.feeder_phase)
			report($sformatf("feeder_phase got %0h want %0h", feeder_phase,
				want.feeder_phase));
		if (peel_phase !== want.peel_phase)
			report($sformatf("peel_phase got %0h want %0h", peel_phase, want.peel_phase));
		if (pending_steps !== want.pending_steps)
			report($sformatf("pending_steps got %0h want %0h", pending_steps,
				want.pending_steps));
	endtask

	// driver: holds a beat until accepted, predicts on acceptance
	always @(posedge clk) begin : drv
		result_t want;
		if (in_valid && in_ready) begin
			advance_feeder(cur_cmd, want);
			status_due.push_back(want);
			n_accepted++;
			if (cur_cmd.operation == OP_ADD) adds_sent++;
			else ticks_sent++;
		end
		if (in_valid && !in_ready) begin
			stall_cycles++;
		end else if (tx_gap > 0) begin
			tx_gap--;
			in_valid <= 1'b0;
		end else if (feed_cmds.size() != 0) begin
			cur_cmd = feed_cmds.pop_front();
			in_valid <= 1'b1;
			operation <= cur_cmd.operation;
			request_count <= cur_cmd.request_count;
			tape_switch <= cur_cmd.tape_switch;
			reverse_button <= cur_cmd.reverse_button;
			encoder_trigger <= cur_cmd.encoder_trigger;
			tx_gap = pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor: every status beat against the oldest prediction
	always @(posedge clk) begin : mon
		result_t want;
		if (out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				report("status beat with nothing due");
			end else begin
				want = status_due.pop_front();
				check_status(want);
			end
			results_seen++;
		end
		if (hold_off) begin
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	// one long receiver stall while the sender keeps offering
	initial begin : hold_off_stretch
		wait (results_seen >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : watchdog
		#4_000_000;
		$display("timeout: %0d status beats still due", status_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic push_cmd(input item_t c);
		feed_cmds.push_back(c);
		n_queued++;
	endtask

	// tick with garbage in the ignored count field
	function automatic item_t mk_tick(input logic sw, input logic btn, input logic trig);
		item_t c;
		c.operation = OP_TICK;
		c.request_count = 8'($urandom);
		c.tape_switch = sw;
		c.reverse_button = btn;
		c.encoder_trigger = trig;
		return c;
	endfunction

	// feed request with garbage in the ignored tick fields
	function automatic item_t mk_add(input logic [7:0] n);
		item_t c;
		c.operation = OP_ADD;
		c.request_count = n;
		c.tape_switch = 1'($urandom_range(1));
		c.reverse_button = 1'($urandom_range(1));
		c.encoder_trigger = 1'($urandom_range(1));
		return c;
	endfunction

	function automatic item_t rand_cmd();
		item_t c;
		c.operation = op_t'($urandom_range(1));
		c.request_count = 8'($urandom);
		c.tape_switch = 1'($urandom_range(1));
		c.reverse_button = 1'($urandom_range(1));
		c.encoder_trigger = 1'($urandom_range(1));
		return c;
	endfunction

	// plausible tick: switch level wanders, trigger common, button rare
	function automatic item_t live_tick();
		if ($urandom_range(99) < 30) sw_level = ~sw_level;
		return mk_tick(sw_level, $urandom_range(99) < 4, $urandom_range(99) < 25);
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_REVERSE_DELAY: delay_cfg = val;
			CFG_DRIVE_SPEED:   speed_cfg = val[6:0];
			default: ;
		endcase
	endtask

	// wait until every queued beat is in and every status beat is out
	task automatic drain();
		@(posedge clk);
		while (n_accepted != n_queued || status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly feed requests followed by enough ticks to play them out
	task automatic queue_random(input int budget);
		int made;
		int r;
		int n;
		int k;
		logic signed [7:0] req;
		made = 0;
		while (made < budget) begin
			r = $urandom_range(99);
			if (r < 12) begin
				n = $urandom_range(4, 1);
				for (k = 0; k < n; k++) push_cmd(rand_cmd());
				made += n;
			end else begin
				if (r < 17) req = 8'($urandom);
				else if (r < 70) req = 8'($urandom_range(3, 1));
				else req = 8'(-$urandom_range(2, 1));
				push_cmd(mk_add(req));
				n = $urandom_range(10, 3);
				if (req < 0) n += int'(delay_cfg) + 2;
				for (k = 0; k < n; k++) push_cmd(live_tick());
				made += n + 1;
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // init clears encoder
		push_cmd(mk_tick(1'b0, 1'b1, 1'b0));     // idle with nothing due, button stops
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // stop back to idle
		push_cmd(mk_add(8'sd127));
		push_cmd(mk_add(8'sd1));                 // clamps at the top
		push_cmd(mk_add(-8'sd128));
		push_cmd(mk_add(-8'sd128));              // clamps at the bottom
		push_cmd(mk_add(8'sd127));
		push_cmd(mk_add(8'sd2));
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // idle to fwd
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // run, tape peels
		push_cmd(mk_tick(1'b0, 1'b1, 1'b1));     // trigger and button, button wins
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // stop
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // nothing due, stays idle
		push_cmd(mk_tick(1'b1, 1'b0, 1'b0));     // still idle, switch high changes nothing
		push_cmd(mk_tick(1'b0, 1'b0, 1'b1));     // trigger outside run, no ack
		push_cmd(mk_tick(1'b1, 1'b0, 1'b0));     // still idle, peeler stays off
		drain();

		// directed reverse with zero delay and speed above the cap
		write_reg(CFG_REVERSE_DELAY, 8'd0);
		write_reg(CFG_DRIVE_SPEED, 8'd127);
		push_cmd(mk_add(-8'sd1));
		push_cmd(mk_tick(1'b1, 1'b0, 1'b0));     // idle to revpeel
		push_cmd(mk_tick(1'b1, 1'b0, 1'b0));     // peeler backs off
		push_cmd(mk_tick(1'b1, 1'b1, 1'b1));     // no wait, sprocket reverses
		push_cmd(mk_tick(1'b0, 1'b0, 1'b0));     // revdone ends on switch low
		push_cmd(mk_tick(1'b0, 1'b0, 1'b1));     // trigger
		push_cmd(mk_tick(1'b1, 1'b0, 1'b0));
		drain();

		// random phases across register settings
		write_reg(CFG_REVERSE_DELAY, REVERSE_DELAY_RST);
		write_reg(CFG_DRIVE_SPEED, {1'b0, DRIVE_SPEED_RST});
		queue_random(200);
		drain();

		calm = 1'b1;
		write_reg(CFG_REVERSE_DELAY, 8'd0);
		write_reg(CFG_DRIVE_SPEED, 8'h7f);
		queue_random(200);
		drain();
		calm = 1'b0;

		write_reg(CFG_REVERSE_DELAY, 8'd255);
		write_reg(CFG_DRIVE_SPEED, 8'd0);
		queue_random(300);
		drain();

		// top bit of the speed write is dropped
		write_reg(CFG_REVERSE_DELAY, 8'd2);
		write_reg(CFG_DRIVE_SPEED, 8'he4);
		queue_random(200);
		drain();

		write_reg(CFG_REVERSE_DELAY, 8'd5);
		write_reg(CFG_DRIVE_SPEED, 8'd50);
		queue_random(200);
		drain();

		write_reg(CFG_REVERSE_DELAY, 8'd1);
		write_reg(CFG_DRIVE_SPEED, 8'd101);
		queue_random(200);
		drain();

		repeat (10) @(posedge clk);
		if (status_due.size() != 0)
			report($sformatf("%0d status beats never arrived", status_due.size()));

		$display("ran %0d ticks and %0d feed requests, %0d cycles with input stalled",
			ticks_sent, adds_sent, stall_cycles);
		$display("saw %0d encoder acks, %0d reverse sprocket starts, %0d clamped sums, %0d errors",
			acks_seen, rev_starts, clamped, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
